// ===== rtl/core/cv2_pkg.sv =====
// Shared types and constants for the strided multichannel convolution block.
`timescale 1ns / 1ps
package cv2_pkg;

  typedef enum logic [1:0] {
    MODE_PIXEL  = 2'd0,
    MODE_WEIGHT = 2'd1,
    MODE_BIAS   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_IN_CH  = 3'd0,
    REG_OUT_CH = 3'd1,
    REG_KERNEL = 3'd2,
    REG_STRIDE = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_FIN
  } state_e;

  // Configuration after clamping to the supported ranges
  typedef struct packed {
    logic [2:0] nic;
    logic [2:0] noc;
    logic [2:0] k;
    logic [2:0] st;
    logic [8:0] w;
    logic [8:0] h;
  } cv2_cfg_t;

  localparam int SampleLanes = 4;
  localparam int SampleW     = 16;
  localparam int FracShift   = 12;

endpackage

// ===== rtl/core/cv2_if.sv =====
// Valid/ready channel interfaces for pixels and table writes in, results out.
`timescale 1ns / 1ps
interface cv2_pix_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] sample_ch0;
  logic signed [15:0] sample_ch1;
  logic signed [15:0] sample_ch2;
  logic signed [15:0] sample_ch3;
  logic [8:0]         table_index;
  logic signed [15:0] table_value;

  modport source (output valid, mode, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  table_index, table_value, input ready);
  modport sink (input valid, mode, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                table_index, table_value, output ready);
endinterface

interface cv2_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_channel;
  logic [7:0]         out_row;
  logic [7:0]         out_col;
  logic signed [15:0] value;
  logic               last;

  modport source (output valid, out_channel, out_row, out_col, value, last, input ready);
  modport sink (input valid, out_channel, out_row, out_col, value, last, output ready);
endinterface

// ===== rtl/core/cv2_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module cv2_ram #(
  parameter int Width = 16,
  parameter int Depth = 400
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/core/cv2_cfg.sv =====
// APB configuration registers with range clamping and image restart pulse.
`timescale 1ns / 1ps
module cv2_cfg #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_KERNEL = 5,
  parameter int MAX_IN_CH  = 4,
  parameter int MAX_OUT_CH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cv2_pkg::cv2_cfg_t cfg_o,
  output logic              restart_o
);
  import cv2_pkg::*;

  localparam int NicMax = (MAX_IN_CH < SampleLanes) ? MAX_IN_CH : SampleLanes;
  localparam int NocMax = (MAX_OUT_CH < 4) ? MAX_OUT_CH : 4;

  logic [2:0] in_ch_q, out_ch_q, kernel_q, stride_q;
  logic [8:0] width_q, height_q;
  logic       wr;
  reg_e       idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= 3'd1;
      out_ch_q <= 3'd1;
      kernel_q <= 3'd3;
      stride_q <= 3'd1;
      width_q  <= 9'd256;
      height_q <= 9'd256;
    end else if (wr) begin
      case (idx)
        REG_IN_CH:  in_ch_q  <= pwdata[2:0];
        REG_OUT_CH: out_ch_q <= pwdata[2:0];
        REG_KERNEL: kernel_q <= pwdata[2:0];
        REG_STRIDE: stride_q <= pwdata[2:0];
        REG_WIDTH:  width_q  <= pwdata[8:0];
        REG_HEIGHT: height_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart_o = 1'b0;
    prdata    = '0;
    case (idx)
      REG_IN_CH:  begin prdata = {29'd0, in_ch_q};  restart_o = wr; end
      REG_OUT_CH: begin prdata = {29'd0, out_ch_q}; restart_o = wr; end
      REG_KERNEL: begin prdata = {29'd0, kernel_q}; restart_o = wr; end
      REG_STRIDE: begin prdata = {29'd0, stride_q}; restart_o = wr; end
      REG_WIDTH:  begin prdata = {23'd0, width_q};  restart_o = wr; end
      REG_HEIGHT: begin prdata = {23'd0, height_q}; restart_o = wr; end
      default: ;
    endcase
  end

  always_comb begin
    cfg_o.nic = (in_ch_q == 3'd0) ? 3'd1 :
                (int'(in_ch_q) > NicMax) ? 3'(NicMax) : in_ch_q;
    cfg_o.noc = (out_ch_q == 3'd0) ? 3'd1 :
                (int'(out_ch_q) > NocMax) ? 3'(NocMax) : out_ch_q;
    cfg_o.k   = (kernel_q == 3'd0) ? 3'd1 :
                (int'(kernel_q) > MAX_KERNEL) ? 3'(MAX_KERNEL) : kernel_q;
    cfg_o.st  = (stride_q == 3'd0) ? 3'd1 : stride_q;
    cfg_o.w   = (width_q == 9'd0) ? 9'd1 :
                (int'(width_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : width_q;
    cfg_o.h   = (height_q == 9'd0) ? 9'd1 :
                (height_q > 9'd256) ? 9'd256 : height_q;
  end
endmodule

// ===== rtl/core/cv2_mac.sv =====
// Multiply-accumulate unit: one sample times weight per cycle, round and saturate.
`timescale 1ns / 1ps
module cv2_mac #(
  parameter int AccW = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] bias_i,
  input  logic               vld_i,
  input  logic [63:0]        line_i,
  input  logic [1:0]         lane_i,
  input  logic signed [15:0] weight_i,
  output logic               busy_o,
  output logic signed [15:0] value_o
);
  import cv2_pkg::*;

  logic signed [15:0]   sample;
  logic signed [31:0]   prod_q;
  logic                 pv_q;
  logic signed [AccW-1:0] acc_q, rnd, quo;

  assign sample = line_i[SampleW*lane_i +: SampleW];
  assign busy_o = pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      prod_q <= sample * weight_i;
    end
    if (start_i) begin
      acc_q <= AccW'(bias_i) <<< FracShift;
    end else if (pv_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  // round half up, then clip to 16 bits
  always_comb begin
    rnd = acc_q + AccW'(2048);
    quo = rnd >>> FracShift;
    if (quo > AccW'(32767)) begin
      value_o = 16'sh7fff;
    end else if (quo < -AccW'(32768)) begin
      value_o = 16'sh8000;
    end else begin
      value_o = quo[15:0];
    end
  end
endmodule

// ===== rtl/core/conv2d_multichannel_strided.sv =====
// Strided multichannel 2D convolution, valid windows, raster pixel input.
//
// Pixels (all input channels in one transfer) arrive in raster order and are
// written into a line memory holding the last MAX_KERNEL rows; weight and bias
// writes are mode transfers. A table write, or a pixel that completes no output
// window, is taken without leaving the idle state. A pixel that completes a
// window whose origin lies on the stride grid runs N_out * K^2 * N_in products,
// with N_out, K and N_in the configured output channels, kernel side and input
// channels: one multiply-accumulate per cycle, fed by the single read port of the
// line memory and of the weight memory, then pipeline drain and result hand-off
// per output channel. Results leave channel 0 first through an output register,
// so the next pixel is taken while the last result waits. The line memory needs
// no clear after reset: a window only reads rows of the image in progress. Any
// register write restarts the image at row 0, column 0.
`timescale 1ns / 1ps
module conv2d_multichannel_strided #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_KERNEL = 5,
  parameter int MAX_IN_CH  = 4,
  parameter int MAX_OUT_CH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cv2_pix_if.sink      pix_i,
  cv2_res_if.source    res_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import cv2_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int SW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int LDepth = MAX_KERNEL * MAX_WIDTH;
  localparam int LAW    = $clog2(LDepth);
  localparam int WCount = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
  localparam int WDepth = (WCount > 1) ? WCount : 2;
  localparam int WAW    = $clog2(WDepth);
  localparam int OCW    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int AccW   = 34 + $clog2(MAX_IN_CH * MAX_KERNEL * MAX_KERNEL + 1);

  cv2_cfg_t cfg;
  logic     restart;

  cv2_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_KERNEL(MAX_KERNEL),
    .MAX_IN_CH (MAX_IN_CH),
    .MAX_OUT_CH(MAX_OUT_CH)
  ) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o    (cfg),
    .restart_o(restart)
  );

  state_e st_q, st_d;

  // image position and stride phase of the current window origin
  logic [7:0]    row_q, orow_q, ocol_q;
  logic [CW-1:0] col_q;
  logic [SW-1:0] rslot_q;
  logic [1:0]    rph_q, cph_q;

  // window walk
  logic [1:0]    oc_q, ic_q, ic1_q;
  logic [2:0]    kr_q, kc_q;
  logic [SW-1:0] slot_q, slot0_q;
  logic [CW-1:0] col0_q;
  logic [7:0]    wrow_q, wcol_q;
  logic          rd_vld_q;

  logic signed [15:0] bias_q [MAX_OUT_CH];

  logic               ovalid_q, olast_q;
  logic [1:0]         ochan_q;
  logic [7:0]         orow_out_q, ocol_out_q;
  logic signed [15:0] oval_q;

  logic pix_acc, is_pix, fire, issue, last_issue, busy, mac_busy, out_free;
  logic fin_load, last_oc, mac_start, row_end, row_on, col_on;
  logic ic_end, kc_end, kr_end;
  logic [1:0]         bias_oc;
  logic signed [15:0] bias_sel, mac_val;
  logic [SW-1:0]      slot0_calc, slot_inc;
  logic [CW-1:0]      col0_calc;
  logic [LAW-1:0]     line_waddr, line_raddr;
  logic [WAW-1:0]     wt_waddr, wt_raddr;
  logic [63:0]        line_rd;
  logic [15:0]        wt_rd;

  assign pix_acc = pix_i.valid & pix_i.ready;
  assign is_pix  = (pix_i.mode == MODE_PIXEL);
  assign row_on  = (int'(row_q) + 1 >= int'(cfg.k));
  assign col_on  = (int'(col_q) + 1 >= int'(cfg.k));
  assign row_end = (int'(col_q) + 1 >= int'(cfg.w));
  assign fire    = is_pix && row_on && col_on && (rph_q == 2'd0) && (cph_q == 2'd0);

  assign ic_end     = (int'(ic_q) + 1 >= int'(cfg.nic));
  assign kc_end     = (int'(kc_q) + 1 >= int'(cfg.k));
  assign kr_end     = (int'(kr_q) + 1 >= int'(cfg.k));
  assign issue      = (st_q == ST_CALC);
  assign last_issue = issue && ic_end && kc_end && kr_end;
  assign busy       = rd_vld_q | mac_busy;
  assign out_free   = !ovalid_q || res_o.ready;
  assign last_oc    = (int'(oc_q) + 1 >= int'(cfg.noc));

  always_comb begin
    int tmp;
    tmp        = int'(rslot_q) + MAX_KERNEL + 1 - int'(cfg.k);
    if (tmp >= MAX_KERNEL) begin
      tmp = tmp - MAX_KERNEL;
    end
    slot0_calc = SW'(tmp);
    col0_calc  = CW'(int'(col_q) + 1 - int'(cfg.k));
    slot_inc   = (int'(slot_q) + 1 >= MAX_KERNEL) ? '0 : SW'(int'(slot_q) + 1);
    line_waddr = LAW'(int'(rslot_q) * MAX_WIDTH + int'(col_q));
    line_raddr = LAW'(int'(slot_q) * MAX_WIDTH + int'(col0_q) + int'(kc_q));
    wt_raddr   = WAW'(((int'(oc_q) * MAX_IN_CH + int'(ic_q)) * MAX_KERNEL + int'(kr_q))
                      * MAX_KERNEL + int'(kc_q));
    wt_waddr   = WAW'(pix_i.table_index);
  end

  always_comb begin
    st_d      = st_q;
    fin_load  = 1'b0;
    mac_start = 1'b0;
    bias_oc   = 2'd0;
    case (st_q)
      ST_IDLE: begin
        if (pix_acc && fire) begin
          st_d      = ST_CALC;
          mac_start = 1'b1;
        end
      end
      ST_CALC: begin
        if (last_issue) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          fin_load = 1'b1;
          if (last_oc) begin
            st_d = ST_IDLE;
          end else begin
            st_d      = ST_CALC;
            mac_start = 1'b1;
            bias_oc   = oc_q + 2'd1;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign bias_sel = bias_q[OCW'(bias_oc)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // image counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      rslot_q <= '0;
      rph_q   <= '0;
      orow_q  <= '0;
      cph_q   <= '0;
      ocol_q  <= '0;
    end else if (restart) begin
      row_q   <= '0;
      col_q   <= '0;
      rslot_q <= '0;
      rph_q   <= '0;
      orow_q  <= '0;
      cph_q   <= '0;
      ocol_q  <= '0;
    end else if (pix_acc && is_pix) begin
      if (row_end) begin
        col_q  <= '0;
        cph_q  <= '0;
        ocol_q <= '0;
        if (int'(row_q) + 1 >= int'(cfg.h)) begin
          row_q   <= '0;
          rslot_q <= '0;
          rph_q   <= '0;
          orow_q  <= '0;
        end else begin
          row_q   <= row_q + 8'd1;
          rslot_q <= (int'(rslot_q) + 1 >= MAX_KERNEL) ? '0 : SW'(int'(rslot_q) + 1);
          if (row_on) begin
            if ({1'b0, rph_q} + 3'd1 == cfg.st) begin
              rph_q  <= '0;
              orow_q <= orow_q + 8'd1;
            end else begin
              rph_q <= rph_q + 2'd1;
            end
          end
        end
      end else begin
        col_q <= col_q + CW'(1);
        if (col_on) begin
          if ({1'b0, cph_q} + 3'd1 == cfg.st) begin
            cph_q  <= '0;
            ocol_q <= ocol_q + 8'd1;
          end else begin
            cph_q <= cph_q + 2'd1;
          end
        end
      end
    end
  end

  // window walk: output channel outermost, input channel innermost
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oc_q     <= '0;
      ic_q     <= '0;
      kr_q     <= '0;
      kc_q     <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (st_q == ST_IDLE && pix_acc && fire) begin
        oc_q <= '0;
        ic_q <= '0;
        kr_q <= '0;
        kc_q <= '0;
      end else if (fin_load && !last_oc) begin
        oc_q <= oc_q + 2'd1;
        ic_q <= '0;
        kr_q <= '0;
        kc_q <= '0;
      end else if (issue) begin
        if (!ic_end) begin
          ic_q <= ic_q + 2'd1;
        end else begin
          ic_q <= '0;
          if (!kc_end) begin
            kc_q <= kc_q + 3'd1;
          end else begin
            kc_q <= '0;
            kr_q <= kr_q + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ic1_q <= ic_q;
    if (st_q == ST_IDLE && pix_acc && fire) begin
      slot0_q <= slot0_calc;
      slot_q  <= slot0_calc;
      col0_q  <= col0_calc;
      wrow_q  <= orow_q;
      wcol_q  <= ocol_q;
    end else if (fin_load && !last_oc) begin
      slot_q <= slot0_q;
    end else if (issue && ic_end && kc_end) begin
      slot_q <= slot_inc;
    end
    if (pix_acc && pix_i.mode == MODE_BIAS && int'(pix_i.table_index) < MAX_OUT_CH) begin
      bias_q[OCW'(pix_i.table_index)] <= pix_i.table_value;
    end
  end

  cv2_ram #(.Width(64), .Depth(LDepth)) u_line (
    .clk_i,
    .we_i   (pix_acc && is_pix),
    .waddr_i(line_waddr),
    .wdata_i({pix_i.sample_ch3, pix_i.sample_ch2, pix_i.sample_ch1, pix_i.sample_ch0}),
    .raddr_i(line_raddr),
    .rdata_o(line_rd)
  );

  cv2_ram #(.Width(16), .Depth(WDepth)) u_weight (
    .clk_i,
    .we_i   (pix_acc && pix_i.mode == MODE_WEIGHT && int'(pix_i.table_index) < WCount),
    .waddr_i(wt_waddr),
    .wdata_i(pix_i.table_value),
    .raddr_i(wt_raddr),
    .rdata_o(wt_rd)
  );

  cv2_mac #(.AccW(AccW)) u_mac (
    .clk_i,
    .rst_ni,
    .start_i (mac_start),
    .bias_i  (bias_sel),
    .vld_i   (rd_vld_q),
    .line_i  (line_rd),
    .lane_i  (ic1_q),
    .weight_i(wt_rd),
    .busy_o  (mac_busy),
    .value_o (mac_val)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (fin_load) begin
      ovalid_q <= 1'b1;
    end else if (res_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      ochan_q    <= oc_q;
      orow_out_q <= wrow_q;
      ocol_out_q <= wcol_q;
      oval_q     <= mac_val;
      olast_q    <= last_oc;
    end
  end

  assign pix_i.ready       = (st_q == ST_IDLE);
  assign res_o.valid       = ovalid_q;
  assign res_o.out_channel = ochan_q;
  assign res_o.out_row     = orow_out_q;
  assign res_o.out_col     = ocol_out_q;
  assign res_o.value       = oval_q;
  assign res_o.last        = olast_q;

`ifndef NO_ASSERTIONS
  a_fin_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FIN) |-> !busy) else $error("result taken before accumulation drained");
  a_last_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && olast_q) |-> (int'(ochan_q) + 1 == int'(cfg.noc)))
    else $error("last flag on wrong output channel");
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> ovalid_q) else $error("loaded result not presented");
  a_oc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CALC) |-> (int'(oc_q) < int'(cfg.noc)))
    else $error("output channel walk past configured count");
`endif
endmodule

// ===== tb/sv/conv2d_multichannel_strided_tb.sv =====
// Self-checking testbench for the strided multichannel 2D convolution block.
`timescale 1ns / 1ps
module conv2d_multichannel_strided_tb;
  import cv2_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] smp [4];
    logic [8:0]  idx;
    logic [15:0] val;
    bit          chk;
    logic [15:0] ev;
  } pix_item_t;

  typedef struct {
    logic [1:0]  ch;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] value;
    logic        last;
  } conv_res_t;

  localparam int HoldCycles = 300;
  localparam int DrainCycles = 500;
  localparam int WatchLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cv2_pix_if pix ();
  cv2_res_if res ();

  conv2d_multichannel_strided uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  int unsigned cfg_reg [6];
  logic [63:0] line_mem [5*256];
  logic [15:0] weight_mem [400];
  logic [15:0] bias_mem [4];
  int unsigned row_cnt, col_cnt;
  conv_res_t   conv_q [$];
  pix_item_t   dir_tbl [$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  bit  apb_xfer = 1'b0;
  int  n_items = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [15:0] window_value(int unsigned oc, int unsigned nic,
                                               int unsigned k, int unsigned r0,
                                               int unsigned c0);
    longint acc;
    longint q;
    logic [63:0] px;
    acc = longint'($signed(bias_mem[oc])) * 4096;
    for (int kr = 0; kr < k; kr++) begin
      for (int kc = 0; kc < k; kc++) begin
        px = line_mem[((r0 + kr) % 5) * 256 + (c0 + kc) % 256];
        for (int ic = 0; ic < nic; ic++) begin
          acc += longint'($signed(px[16*ic +: 16])) *
                 longint'($signed(weight_mem[((oc*4 + ic)*5 + kr)*5 + kc]));
        end
      end
    end
    q = (acc + 2048) >>> 12;  // round half up
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic void conv_predict(pix_item_t it);
    int unsigned nic, noc, k, st, w, h, r, c, r0, c0;
    conv_res_t   e;
    if (it.mode == MODE_WEIGHT) begin
      if (it.idx < 400) weight_mem[it.idx] = it.val;
    end else if (it.mode == MODE_BIAS) begin
      if (it.idx < 4) bias_mem[it.idx] = it.val;
    end else if (it.mode == MODE_PIXEL) begin
      nic = clampu(cfg_reg[REG_IN_CH], 1, 4);
      noc = clampu(cfg_reg[REG_OUT_CH], 1, 4);
      k = clampu(cfg_reg[REG_KERNEL], 1, 5);
      st = cfg_reg[REG_STRIDE] == 0 ? 1 : cfg_reg[REG_STRIDE];
      w = clampu(cfg_reg[REG_WIDTH], 1, 256);
      h = clampu(cfg_reg[REG_HEIGHT], 1, 256);
      r = row_cnt;
      c = col_cnt;
      line_mem[(r % 5) * 256 + c % 256] = {it.smp[3], it.smp[2], it.smp[1], it.smp[0]};
      if (r + 1 >= k && c + 1 >= k) begin
        r0 = r + 1 - k;
        c0 = c + 1 - k;
        if (r0 % st == 0 && c0 % st == 0) begin
          for (int oc = 0; oc < noc; oc++) begin
            e.ch = oc[1:0];
            e.row = 8'(r0 / st);
            e.col = 8'(c0 / st);
            e.value = window_value(oc, nic, k, r0, c0);
            e.last = (oc + 1 == noc);
            conv_q.push_back(e);
          end
          if (it.chk) conv_q[$].value = it.ev;
        end
      end
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      if (conv_q.size() == 0) begin
        $error("unexpected result ch=%0d row=%0d col=%0d value=%0d",
               res.out_channel, res.out_row, res.out_col, res.value);
        errors++;
      end else begin
        if (res.out_channel !== conv_q[0].ch) begin
          $error("out_channel: expected %0d, got %0d", conv_q[0].ch, res.out_channel);
          errors++;
        end
        if (res.out_row !== conv_q[0].row) begin
          $error("out_row: expected %0d, got %0d", conv_q[0].row, res.out_row);
          errors++;
        end
        if (res.out_col !== conv_q[0].col) begin
          $error("out_col: expected %0d, got %0d", conv_q[0].col, res.out_col);
          errors++;
        end
        if (res.value !== conv_q[0].value) begin
          $error("value: expected %0d, got %0d", $signed(conv_q[0].value),
                 $signed(res.value));
          errors++;
        end
        if (res.last !== conv_q[0].last) begin
          $error("last: expected %0d, got %0d", conv_q[0].last, res.last);
          errors++;
        end
        void'(conv_q.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || apb_xfer) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result receiver with random and long stalls
  initial begin
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        res.ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      res.ready = 1'b1;
    end
  end

  task automatic send_item(pix_item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      pix.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    pix.mode = it.mode;
    pix.sample_ch0 = it.smp[0];
    pix.sample_ch1 = it.smp[1];
    pix.sample_ch2 = it.smp[2];
    pix.sample_ch3 = it.smp[3];
    pix.table_index = it.idx;
    pix.table_value = it.val;
    pix.valid = 1'b1;
    do @(posedge clk_i); while (!pix.ready);
    conv_predict(it);
    @(negedge clk_i);
    // a following item raises valid again in this same step unless it draws a random gap first
    pix.valid = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    pix.valid = 1'b0;
    while (conv_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic apb_write(reg_e r, int unsigned v);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    apb_xfer = 1'b1;
    cfg_reg[r] = v;
    row_cnt = 0;
    col_cnt = 0;
    @(negedge clk_i);
    apb_xfer = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(int unsigned nic, int unsigned noc, int unsigned k,
                            int unsigned st, int unsigned w, int unsigned h);
    wait_idle();
    apb_write(REG_IN_CH, nic);
    apb_write(REG_OUT_CH, noc);
    apb_write(REG_KERNEL, k);
    apb_write(REG_STRIDE, st);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
  endtask

  function automatic pix_item_t make_item(logic [1:0] m, logic [15:0] s, logic [8:0] idx,
                                          logic [15:0] val, bit chk, logic [15:0] ev);
    pix_item_t it;
    it.mode = m;
    for (int i = 0; i < 4; i++) it.smp[i] = s;
    it.idx = idx;
    it.val = val;
    it.chk = chk;
    it.ev = ev;
    return it;
  endfunction

  function automatic logic [15:0] rand_sample();
    if ($urandom_range(0, 1) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 16'h07FF) - 16'h0400);
  endfunction

  function automatic logic [15:0] rand_weight();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 16'h1FFF) - 16'h1000);
  endfunction

  function automatic pix_item_t rand_pixel();
    pix_item_t it;
    it = make_item(MODE_PIXEL, 16'h0, 9'h0, 16'($urandom), 1'b0, 16'h0);
    for (int i = 0; i < 4; i++) it.smp[i] = rand_sample();
    it.idx = 9'($urandom);
    return it;
  endfunction

  // n pixels plus some noise: stray table writes and unused mode
  task automatic run_pixels(int unsigned n);
    pix_item_t it;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        it = make_item(MODE_WEIGHT, rand_sample(), 9'($urandom), rand_weight(), 1'b0, 16'h0);
        send_item(it);
      end else if (pick == 1) begin
        it = make_item(MODE_BIAS, rand_sample(), 9'($urandom_range(0, 7)), rand_weight(),
                       1'b0, 16'h0);
        send_item(it);
      end else if (pick == 2) begin
        it = make_item(2'd3, rand_sample(), 9'($urandom), 16'($urandom), 1'b0, 16'h0);
        send_item(it);
      end
      send_item(rand_pixel());
      n_items++;
      if (n_items >= 130) quiet = 1'b1;
    end
  endtask

  initial begin
    int unsigned k, w, h, nic, noc;
    pix.valid = 1'b0;
    pix.mode = MODE_PIXEL;
    pix.sample_ch0 = '0;
    pix.sample_ch1 = '0;
    pix.sample_ch2 = '0;
    pix.sample_ch3 = '0;
    pix.table_index = '0;
    pix.table_value = '0;
    cfg_reg = '{1, 1, 3, 1, 256, 256};
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (weight_mem[i]) weight_mem[i] = '0;
    foreach (bias_mem[i]) bias_mem[i] = '0;
    row_cnt = 0;
    col_cnt = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: 1x1 kernel, one channel, small image
    dir_tbl.push_back(make_item(MODE_WEIGHT, 16'h0, 9'd0, 16'h1000, 0, 16'h0));
    dir_tbl.push_back(make_item(MODE_BIAS, 16'h0, 9'd0, 16'h0000, 0, 16'h0));
    dir_tbl.push_back(make_item(MODE_WEIGHT, 16'h0, 9'd400, 16'h1234, 0, 16'h0));
    dir_tbl.push_back(make_item(MODE_WEIGHT, 16'h0, 9'd511, 16'hFFFF, 0, 16'h0));
    dir_tbl.push_back(make_item(MODE_BIAS, 16'h0, 9'd4, 16'h5555, 0, 16'h0));
    dir_tbl.push_back(make_item(MODE_BIAS, 16'h0, 9'd511, 16'hAAAA, 0, 16'h0));
    dir_tbl.push_back(make_item(2'd3, 16'h7FFF, 9'd0, 16'h7FFF, 0, 16'h0));
    dir_tbl.push_back(make_item(MODE_PIXEL, 16'h7FFF, 9'd0, 16'h0, 1, 16'h7FFF));
    dir_tbl.push_back(make_item(MODE_PIXEL, 16'h8000, 9'd0, 16'h0, 1, 16'h8000));
    dir_tbl.push_back(make_item(MODE_PIXEL, 16'h0001, 9'd0, 16'h0, 1, 16'h0001));
    dir_tbl.push_back(make_item(MODE_BIAS, 16'h0, 9'd0, 16'h7FFF, 0, 16'h0));
    dir_tbl.push_back(make_item(MODE_PIXEL, 16'h7FFF, 9'd0, 16'h0, 1, 16'h7FFF));
    dir_tbl.push_back(make_item(MODE_BIAS, 16'h0, 9'd0, 16'h8000, 0, 16'h0));
    dir_tbl.push_back(make_item(MODE_PIXEL, 16'h8000, 9'd0, 16'h0, 1, 16'h8000));
    dir_tbl.push_back(make_item(MODE_BIAS, 16'h0, 9'd0, 16'h0000, 0, 16'h0));
    dir_tbl.push_back(make_item(MODE_WEIGHT, 16'h0, 9'd0, 16'h8000, 0, 16'h0));
    dir_tbl.push_back(make_item(MODE_PIXEL, 16'h8000, 9'd0, 16'h0, 1, 16'h7FFF));
    dir_tbl.push_back(make_item(MODE_PIXEL, 16'h0000, 9'd0, 16'h0, 1, 16'h0000));
    // half an LSB rounds up
    dir_tbl.push_back(make_item(MODE_WEIGHT, 16'h0, 9'd0, 16'h0800, 0, 16'h0));
    dir_tbl.push_back(make_item(MODE_PIXEL, 16'h0001, 9'd0, 16'h0, 1, 16'h0001));
    dir_tbl.push_back(make_item(MODE_PIXEL, 16'hFFFF, 9'd0, 16'h0, 1, 16'h0000));
    set_config(1, 1, 1, 1, 4, 4);
    foreach (dir_tbl[i]) send_item(dir_tbl[i]);

    // load every weight a window below can reach: all channel pairs up to 2x2,
    // the full 5x5 kernel only for input 0 to output 0
    for (int oc = 0; oc < 4; oc++)
      for (int ic = 0; ic < 4; ic++)
        for (int kr = 0; kr < 2; kr++)
          for (int kc = 0; kc < 2; kc++)
            send_item(make_item(MODE_WEIGHT, rand_sample(),
                                9'(((oc*4 + ic)*5 + kr)*5 + kc), rand_weight(), 0, 16'h0));
    for (int kr = 0; kr < 5; kr++)
      for (int kc = 0; kc < 5; kc++)
        if (kr >= 2 || kc >= 2)
          send_item(make_item(MODE_WEIGHT, rand_sample(), 9'(kr*5 + kc), rand_weight(),
                              0, 16'h0));
    for (int i = 0; i < 4; i++)
      send_item(make_item(MODE_BIAS, rand_sample(), 9'(i), rand_weight(), 0, 16'h0));

    // fixed corner configurations, some with out-of-range register values
    set_config(4, 4, 2, 1, 3, 3);
    hold_req = 1'b1;
    run_pixels(9);
    set_config(0, 7, 0, 0, 3, 3);
    run_pixels(9);
    set_config(0, 0, 6, 1, 6, 5);
    run_pixels(30);
    set_config(7, 1, 2, 3, 5, 5);
    run_pixels(25);
    set_config(2, 2, 4, 1, 3, 5);   // kernel wider than image
    run_pixels(6);
    set_config(3, 2, 2, 1, 0, 0);   // 1x1 image, never a full window
    run_pixels(3);
    set_config(1, 2, 1, 4, 511, 1);
    run_pixels(10);
    set_config(1, 1, 1, 1, 1, 256);
    run_pixels(8);
    set_config(2, 3, 2, 1, 256, 300);
    run_pixels(6);

    // random images; kernels above 2x2 use one channel each way
    while (n_items < 150) begin
      k = $urandom_range(1, 5);
      w = $urandom_range(k, 5);
      h = $urandom_range(k, 5);
      if (k > 2) begin
        nic = 1;
        noc = 1;
      end else begin
        nic = $urandom_range(1, 4);
        noc = $urandom_range(1, 4);
      end
      set_config(nic, noc, k, $urandom_range(1, 4), w, h);
      run_pixels(w * h + $urandom_range(0, w));
    end

    @(negedge clk_i);
    pix.valid = 1'b0;
    while (conv_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
